FILE: sv/sfc_pkg.sv
// Shared constants, codes and types of the stereo FIR convolver.
// Used by every module of the block; depends on nothing.
package sfc_pkg;

   // Sizes of the stores and the arithmetic.
   localparam int MAX_TAPS   = 1024;
   localparam int TAP_ADDR_W = 10;
   localparam int COUNT_W    = 11;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 40;
   localparam int GAIN_W     = 16;
   localparam int UNITY_GAIN = 32768;
   localparam int FRAC_BITS  = 15;

   // Opcodes of an input word.
   localparam logic [1:0] OP_LOAD_TAP = 2'd0;
   localparam logic [1:0] OP_PROCESS  = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_WET_MIX   = 2'd1;
   localparam logic [1:0] CSR_TAP_COUNT = 2'd2;

   // Control of one history lane.
   typedef struct packed {
      logic                  wr_en;
      logic [TAP_ADDR_W-1:0] wr_addr;
      logic                  rd_en;
      logic [TAP_ADDR_W-1:0] rd_addr;
      logic                  acc_clear;
   } sfc_lane_ctrl_type;

   // Operands handed to the mixer.
   typedef struct packed {
      logic                       start;
      logic [GAIN_W-1:0]          wet_gain;
      logic signed [SAMPLE_W-1:0] dry_left;
      logic signed [SAMPLE_W-1:0] dry_right;
      logic signed [ACC_W-1:0]    acc_left;
      logic signed [ACC_W-1:0]    acc_right;
   } sfc_mix_req_type;

   // Result of the mixer.
   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       clipped;
   } sfc_mix_result_type;

endpackage

FILE: sv/sfc_lane.sv
// One channel lane: history ring memory and a saturating multiply-accumulate.
// Depends on sfc_pkg; the tap word is read by the top level and shared.
module sfc_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  sfc_pkg::sfc_lane_ctrl_type         ctrl,
   input  logic signed [sfc_pkg::SAMPLE_W-1:0] wr_data,
   input  logic signed [sfc_pkg::SAMPLE_W-1:0] tap_q,
   output logic signed [sfc_pkg::ACC_W-1:0]    acc
);
   import sfc_pkg::*;

   logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] hist_q_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [ACC_W:0]      sum_wide;
   logic                       read_vld_ff;
   logic                       prod_vld_ff;

   // History memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         hist_mem[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         hist_q_ff <= hist_mem[ctrl.rd_addr];
      end
   end

   // Product of the tap and the history sample, then a saturating add.
   assign prod_in  = tap_q * hist_q_ff;
   assign sum_wide = {acc_ff[ACC_W-1], acc_ff}
                   + {{(ACC_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         acc_in = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_in = sum_wide[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         read_vld_ff <= ctrl.rd_en;
         prod_vld_ff <= read_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (read_vld_ff) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: sv/sfc_mixer.sv
// Merging stage: wet/dry mix of both lanes on one shared multiplier,
// rounding, saturation and the common clip flag. Depends on sfc_pkg.
module sfc_mixer (
   input  logic                        clock,
   input  logic                        reset,
   input  sfc_pkg::sfc_mix_req_type    req,
   output sfc_pkg::sfc_mix_result_type result
);
   import sfc_pkg::*;

   localparam int MUL_A_W = GAIN_W + 1;
   localparam int MUL_B_W = ACC_W - 16 + 1;
   localparam int MUL_W   = MUL_A_W + MUL_B_W;
   localparam int SUM_W   = 58;
   localparam int RND_SH  = 2 * FRAC_BITS;
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (RND_SH - 1);
   localparam logic [3:0] LAST_MUL  = 4'd5;
   localparam logic [3:0] FINISH    = 4'd7;

   logic [3:0]                 step_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [GAIN_W-1:0]          dry_gain;
   logic signed [MUL_A_W-1:0]  op_a;
   logic signed [MUL_B_W-1:0]  op_b;
   logic [4:0]                 shift;
   logic                       right_sel;
   logic signed [MUL_W-1:0]    prod_ff;
   logic [4:0]                 pshift_ff;
   logic                       pright_ff;
   logic                       pvld_ff;
   logic signed [SUM_W-1:0]    term;
   logic signed [SUM_W-1:0]    sum_l_ff;
   logic signed [SUM_W-1:0]    sum_r_ff;
   logic signed [SAMPLE_W-1:0] left_ff;
   logic signed [SAMPLE_W-1:0] right_ff;
   logic                       clip_ff;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;
   logic                       clip_l;
   logic                       clip_r;

   // Round half up to Q1.15 and saturate one channel.
   function automatic logic signed [SAMPLE_W:0] round_sat(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] r;
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      r  = (s + ROUND_BIAS) >>> RND_SH;
      hi = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
      lo = -hi - SUM_W'(1);
      if (r > hi) begin
         round_sat = {1'b1, hi[SAMPLE_W-1:0]};
      end else if (r < lo) begin
         round_sat = {1'b1, lo[SAMPLE_W-1:0]};
      end else begin
         round_sat = {1'b0, r[SAMPLE_W-1:0]};
      end
   endfunction

   assign dry_gain = GAIN_W'(UNITY_GAIN) - req.wet_gain;

   // Operand selection: dry term, upper and lower accumulator halves per channel.
   always_comb begin
      op_a      = '0;
      op_b      = '0;
      shift     = '0;
      right_sel = 1'b0;
      case (step_ff)
         4'd0: begin
            op_a  = {1'b0, dry_gain};
            op_b  = MUL_B_W'(req.dry_left);
            shift = 5'(FRAC_BITS);
         end
         4'd1: begin
            op_a  = {1'b0, req.wet_gain};
            op_b  = MUL_B_W'($signed(req.acc_left[ACC_W-1:16]));
            shift = 5'd16;
         end
         4'd2: begin
            op_a  = {1'b0, req.wet_gain};
            op_b  = {{(MUL_B_W-16){1'b0}}, req.acc_left[15:0]};
         end
         4'd3: begin
            op_a      = {1'b0, dry_gain};
            op_b      = MUL_B_W'(req.dry_right);
            shift     = 5'(FRAC_BITS);
            right_sel = 1'b1;
         end
         4'd4: begin
            op_a      = {1'b0, req.wet_gain};
            op_b      = MUL_B_W'($signed(req.acc_right[ACC_W-1:16]));
            shift     = 5'd16;
            right_sel = 1'b1;
         end
         4'd5: begin
            op_a      = {1'b0, req.wet_gain};
            op_b      = {{(MUL_B_W-16){1'b0}}, req.acc_right[15:0]};
            right_sel = 1'b1;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   assign term = {{(SUM_W-MUL_W){prod_ff[MUL_W-1]}}, prod_ff} <<< pshift_ff;
   assign {clip_l, left_in}  = round_sat(sum_l_ff);
   assign {clip_r, right_in} = round_sat(sum_r_ff);

   // Step sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pvld_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            step_ff <= '0;
            busy_ff <= 1'b1;
            pvld_ff <= 1'b0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 4'd1;
            pvld_ff <= (step_ff <= LAST_MUL);
            if (step_ff == FINISH) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Products, channel sums and the final words.
   always_ff @(posedge clock) begin
      if (req.start) begin
         sum_l_ff <= '0;
         sum_r_ff <= '0;
      end else if (pvld_ff) begin
         if (pright_ff) begin
            sum_r_ff <= sum_r_ff + term;
         end else begin
            sum_l_ff <= sum_l_ff + term;
         end
      end
      if (busy_ff && step_ff <= LAST_MUL) begin
         prod_ff   <= op_a * op_b;
         pshift_ff <= shift;
         pright_ff <= right_sel;
      end
      if (busy_ff && step_ff == FINISH) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         clip_ff  <= clip_l | clip_r;
      end
   end

   assign result.done    = done_ff;
   assign result.left    = left_ff;
   assign result.right   = right_ff;
   assign result.clipped = clip_ff;

endmodule

FILE: sv/stereo_fir_convolver_wet_dry_top.sv
// Top level of the stereo FIR convolver with wet/dry mix: controller,
// tap memory, two history lanes and the mixer. Depends on sfc_pkg,
// sfc_lane and sfc_mixer.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_stall    opcode, tap_index, tap_value, left_in, right_in
//   rsp_      out        rsp_valid / rsp_stall    left_out, right_out, clipped
//   csr_      in         csr_write                csr_index, csr_data
//
// A tap load or an unused opcode leaves the controller idle; a clear word starts
// the zeroing pass. A sample pair in pass-through goes straight to the output
// register; a convolved pair takes one tap-memory and history read per tap,
// shared by both lanes. After reset and after every clear word the history rings
// are zeroed entry by entry while no word is accepted; csr writes are taken always.
// A new word is accepted while the last result still waits in the output register.
module stereo_fir_convolver_wet_dry_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_opcode,
   input  logic [sfc_pkg::TAP_ADDR_W-1:0]        req_tap_index,
   input  logic signed [sfc_pkg::SAMPLE_W-1:0]   req_tap_value,
   input  logic signed [sfc_pkg::SAMPLE_W-1:0]   req_left_in,
   input  logic signed [sfc_pkg::SAMPLE_W-1:0]   req_right_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sfc_pkg::SAMPLE_W-1:0]   rsp_left_out,
   output logic signed [sfc_pkg::SAMPLE_W-1:0]   rsp_right_out,
   output logic                                  rsp_clipped,
   input  logic                                  csr_write,
   input  logic [1:0]                            csr_index,
   input  logic [sfc_pkg::GAIN_W-1:0]            csr_data
);
   import sfc_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_RUN   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_MIX   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   localparam logic [1:0] DRAIN_LAST = 2'd2;

   state_type               state_ff, state_in;
   logic [TAP_ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [TAP_ADDR_W-1:0]   wp_ff, wp_in;
   logic [TAP_ADDR_W-1:0]   rp_ff, rp_in;
   logic [TAP_ADDR_W-1:0]   k_ff, k_in;
   logic [COUNT_W-1:0]      n_ff, n_in;
   logic [1:0]              drain_ff, drain_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    enable_ff;
   logic [GAIN_W-1:0]       wet_mix_ff;
   logic [COUNT_W-1:0]      tap_count_ff;

   logic                    pass_ff;
   logic [GAIN_W-1:0]       wm_ff;
   logic signed [SAMPLE_W-1:0] dry_l_ff;
   logic signed [SAMPLE_W-1:0] dry_r_ff;
   logic signed [SAMPLE_W-1:0] rsp_left_ff;
   logic signed [SAMPLE_W-1:0] rsp_right_ff;
   logic                    rsp_clip_ff;

   logic signed [SAMPLE_W-1:0] tap_mem [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] tap_q_ff;

   logic                    accept;
   logic                    do_load;
   logic                    do_process;
   logic                    do_clear;
   logic                    active;
   logic [COUNT_W-1:0]      n_cur;
   logic [COUNT_W-1:0]      n_last;
   logic [TAP_ADDR_W-1:0]   wp_eff;
   logic [COUNT_W-1:0]      wp_next;
   logic [TAP_ADDR_W-1:0]   wp_adv;
   logic [GAIN_W-1:0]       wm_cur;
   logic                    out_free;
   logic                    load_rsp;

   sfc_lane_ctrl_type       lane_ctrl;
   logic signed [SAMPLE_W-1:0] left_wr_data;
   logic signed [SAMPLE_W-1:0] right_wr_data;
   logic signed [ACC_W-1:0] acc_left;
   logic signed [ACC_W-1:0] acc_right;
   sfc_mix_req_type         mix_req;
   sfc_mix_result_type      mix_result;

   // Word decode and the pointer arithmetic used at acceptance.
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign do_load    = accept && (req_opcode == OP_LOAD_TAP);
   assign do_process = accept && (req_opcode == OP_PROCESS);
   assign do_clear   = accept && (req_opcode == OP_CLEAR);

   assign n_cur   = (tap_count_ff > COUNT_W'(MAX_TAPS)) ? COUNT_W'(MAX_TAPS) : tap_count_ff;
   assign active  = enable_ff && (n_cur != '0);
   assign wp_eff  = ({1'b0, wp_ff} >= n_cur) ? '0 : wp_ff;
   assign wp_next = {1'b0, wp_eff} + COUNT_W'(1);
   assign wp_adv  = (wp_next >= n_cur) ? '0 : wp_next[TAP_ADDR_W-1:0];
   assign n_last  = n_ff - COUNT_W'(1);
   assign wm_cur  = (wet_mix_ff > GAIN_W'(UNITY_GAIN)) ? GAIN_W'(UNITY_GAIN) : wet_mix_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = (state_ff == ST_OUT) && out_free;

   // Controller state machine.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + TAP_ADDR_W'(1);
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (do_clear) begin
               state_in   = ST_CLEAR;
               clr_cnt_in = '0;
               wp_in      = '0;
            end else if (do_process && active) begin
               state_in = ST_RUN;
               rp_in    = wp_eff;
               k_in     = '0;
               n_in     = n_cur;
               wp_in    = wp_adv;
            end else if (do_process) begin
               state_in = ST_OUT;
            end
         end
         ST_RUN: begin
            k_in  = k_ff + TAP_ADDR_W'(1);
            rp_in = (rp_ff == '0) ? n_last[TAP_ADDR_W-1:0] : rp_ff - TAP_ADDR_W'(1);
            if ({1'b0, k_ff} == n_last) begin
               state_in = ST_DRAIN;
               drain_in = '0;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (mix_result.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         wet_mix_ff   <= '0;
         tap_count_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_data[0];
            CSR_WET_MIX:   wet_mix_ff   <= csr_data;
            CSR_TAP_COUNT: tap_count_ff <= csr_data[COUNT_W-1:0];
            default:       enable_ff    <= enable_ff;
         endcase
      end
   end

   // Operands latched with an accepted sample word, and the output word.
   always_ff @(posedge clock) begin
      if (do_process) begin
         pass_ff  <= !active;
         wm_ff    <= wm_cur;
         dry_l_ff <= req_left_in;
         dry_r_ff <= req_right_in;
      end
      if (load_rsp) begin
         rsp_left_ff  <= pass_ff ? dry_l_ff : mix_result.left;
         rsp_right_ff <= pass_ff ? dry_r_ff : mix_result.right;
         rsp_clip_ff  <= pass_ff ? 1'b0 : mix_result.clipped;
      end
   end

   // Tap memory: written by a load word, read once per tap during a run.
   always_ff @(posedge clock) begin
      if (do_load) begin
         tap_mem[req_tap_index] <= req_tap_value;
      end
      if (state_ff == ST_RUN) begin
         tap_q_ff <= tap_mem[k_ff];
      end
   end

   // Lane control, shared by both channels.
   always_comb begin
      lane_ctrl.wr_en     = (state_ff == ST_CLEAR) || (do_process && active);
      lane_ctrl.wr_addr   = (state_ff == ST_CLEAR) ? clr_cnt_ff : wp_eff;
      lane_ctrl.rd_en     = (state_ff == ST_RUN);
      lane_ctrl.rd_addr   = rp_ff;
      lane_ctrl.acc_clear = do_process;
   end

   assign left_wr_data  = (state_ff == ST_CLEAR) ? '0 : req_left_in;
   assign right_wr_data = (state_ff == ST_CLEAR) ? '0 : req_right_in;

   sfc_lane u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (lane_ctrl),
      .wr_data (left_wr_data),
      .tap_q   (tap_q_ff),
      .acc     (acc_left)
   );

   sfc_lane u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (lane_ctrl),
      .wr_data (right_wr_data),
      .tap_q   (tap_q_ff),
      .acc     (acc_right)
   );

   // Mixer start once both accumulators have settled.
   always_comb begin
      mix_req.start     = (state_ff == ST_DRAIN) && (drain_ff == DRAIN_LAST);
      mix_req.wet_gain  = wm_ff;
      mix_req.dry_left  = dry_l_ff;
      mix_req.dry_right = dry_r_ff;
      mix_req.acc_left  = acc_left;
      mix_req.acc_right = acc_right;
   end

   sfc_mixer u_mixer (
      .clock  (clock),
      .reset  (reset),
      .req    (mix_req),
      .result (mix_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;
   assign rsp_clipped   = rsp_clip_ff;

endmodule
